@@ hw/rtl/gdad_pkg.sv @@
// ----------------------------------------------------------------------------
// gdad_pkg
// Shared types, widths and calendar constants for the date-advance unit.
// ----------------------------------------------------------------------------
package gdad_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int MOD25_W = 5;
  localparam int QUOT_W  = 10;
  localparam int LEN_W   = 5;

  // floor(y * RECIP_25 / 2^RECIP_SHIFT) == floor(y / 25) for any 14-bit year
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 17;
  localparam logic [RECIP_W-1:0] RECIP_25 = 13'd5243;
  localparam int PROD_W = YEAR_W + RECIP_W;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [MOD25_W-1:0] MOD25_TOP = 5'd24;
  localparam logic [YEAR_W-1:0]  YEAR_TOP  = 14'h3FFF;

  typedef struct packed {
    logic load;      // capture a new transaction
    logic calc_mod;  // year mod 25 from registered quotient
    logic step;      // advance one month
  } gdad_cmd_t;

  typedef struct packed {
    logic fits;      // day count fits in current month
  } gdad_status_t;

  function automatic logic [LEN_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
    logic [LEN_W-1:0] len;
    begin
      case (month)
        4'd2:                       len = leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
        default:                    len = 5'd31;
      endcase
      return len;
    end
  endfunction

endpackage

@@ hw/rtl/gregorian_date_add_days_unit.sv @@
// From start to the done strobe the unit loads, forms the year residue, walks months, then strobes done.
// A new transaction is taken only from idle, so the unit finishes one date before it accepts the next;
// busy stays high until done has shown.
// The month walk in the datapath advances one month per cycle.
// Result is valid only in the done cycle; the receiver cannot stall.
// Synchronous active-high reset returns the sequencer to idle.
// ----------------------------------------------------------------------------
// gregorian_date_add_days_unit
// Adds a day count to a Gregorian date by walking forward month by month.
// ----------------------------------------------------------------------------
module gregorian_date_add_days_unit #(
  parameter int ADD_DAYS_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  output logic                          done,
  input  logic [gdad_pkg::YEAR_W-1:0]   start_year,
  input  logic [gdad_pkg::MONTH_W-1:0]  start_month,
  input  logic [gdad_pkg::DAY_W-1:0]    start_day,
  input  logic [ADD_DAYS_BITS-1:0]      add_days,
  output logic [gdad_pkg::YEAR_W-1:0]   result_year,
  output logic [gdad_pkg::MONTH_W-1:0]  result_month,
  output logic [gdad_pkg::DAY_W-1:0]    result_day
);
  import gdad_pkg::*;

  gdad_cmd_t    cmd;
  gdad_status_t status;

  gdad_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  gdad_dp #(
    .ADD_DAYS_BITS (ADD_DAYS_BITS)
  ) u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .start_year   (start_year),
    .start_month  (start_month),
    .start_day    (start_day),
    .add_days     (add_days),
    .status       (status),
    .result_year  (result_year),
    .result_month (result_month),
    .result_day   (result_day)
  );

endmodule

@@ hw/rtl/gdad_ctrl.sv @@
// ----------------------------------------------------------------------------
// gdad_ctrl
// Sequencer: load, year residue, month walk, result strobe.
// ----------------------------------------------------------------------------
module gdad_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  gdad_pkg::gdad_status_t status,
  output gdad_pkg::gdad_cmd_t   cmd,
  output logic                  busy,
  output logic                  done
);
  import gdad_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MOD  = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next   = state;
    cmd.load     = 1'b0;
    cmd.calc_mod = 1'b0;
    cmd.step     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.calc_mod = 1'b1;
        state_next   = ST_WALK;
      end
      ST_WALK: begin
        if (status.fits) begin
          state_next = ST_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

endmodule

@@ hw/rtl/gdad_dp.sv @@
// ----------------------------------------------------------------------------
// gdad_dp
// Date registers, month length lookup and one-month-per-cycle walk.
// ----------------------------------------------------------------------------
module gdad_dp #(
  parameter int ADD_DAYS_BITS = 16
) (
  input  logic                          clk,
  input  gdad_pkg::gdad_cmd_t           cmd,
  input  logic [gdad_pkg::YEAR_W-1:0]   start_year,
  input  logic [gdad_pkg::MONTH_W-1:0]  start_month,
  input  logic [gdad_pkg::DAY_W-1:0]    start_day,
  input  logic [ADD_DAYS_BITS-1:0]      add_days,
  output gdad_pkg::gdad_status_t        status,
  output logic [gdad_pkg::YEAR_W-1:0]   result_year,
  output logic [gdad_pkg::MONTH_W-1:0]  result_month,
  output logic [gdad_pkg::DAY_W-1:0]    result_day
);
  import gdad_pkg::*;

  localparam int DW = ADD_DAYS_BITS + 1;

  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [DW-1:0]      day;
  logic [QUOT_W-1:0]  quot;
  logic [MOD25_W-1:0] mod25;

  logic [MONTH_W-1:0] month_in;
  logic [DAY_W-1:0]   day_in;
  logic [PROD_W-1:0]  prod;
  logic [YEAR_W-1:0]  quot25;
  logic [YEAR_W-1:0]  rem;
  logic               leap;
  logic [LEN_W-1:0]   len;

  always_comb begin
    month_in = start_month;
    if (start_month == '0) begin
      month_in = MONTH_JAN;
    end else if (start_month > MONTH_DEC) begin
      month_in = MONTH_DEC;
    end
    day_in = (start_day == '0) ? DAY_W'(1) : start_day;
  end

  assign prod   = PROD_W'(start_year) * PROD_W'(RECIP_25);
  // quot * 25 as shift-add
  assign quot25 = (YEAR_W'(quot) << 4) + (YEAR_W'(quot) << 3) + YEAR_W'(quot);
  assign rem    = year - quot25;

  // divisible by 100: by 4 and by 25; by 400: by 16 and by 25
  assign leap = (year[1:0] == 2'd0) && ((mod25 != '0) || (year[3:0] == 4'd0));
  assign len  = month_len(month, leap);
  assign status.fits = (day <= DW'(len));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      year  <= start_year;
      month <= month_in;
      day   <= DW'(day_in) + DW'(add_days);
      quot  <= prod[RECIP_SHIFT +: QUOT_W];
    end else if (cmd.calc_mod) begin
      mod25 <= rem[MOD25_W-1:0];
    end else if (cmd.step) begin
      day <= day - DW'(len);
      if (month == MONTH_DEC) begin
        month <= MONTH_JAN;
        year  <= year + YEAR_W'(1);
        // wrap to year zero restarts the residue
        if (year == YEAR_TOP || mod25 == MOD25_TOP) begin
          mod25 <= '0;
        end else begin
          mod25 <= mod25 + MOD25_W'(1);
        end
      end else begin
        month <= month + MONTH_W'(1);
      end
    end
  end

  assign result_year  = year;
  assign result_month = month;
  assign result_day   = day[DAY_W-1:0];

endmodule

@@ tb/sv/tb_gregorian_date_add_days_unit.sv @@
// ----------------------------------------------------------------------------
// tb_gregorian_date_add_days_unit
// Self-checking bench for the date-advance unit: directed calendar corner
// cases, then random dates and day counts under varying start gaps.
// Every result is checked against a month-walk predictor.
// ----------------------------------------------------------------------------
module tb_gregorian_date_add_days_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import gdad_pkg::*;

  localparam int ADD_W      = 16;
  localparam int STALL_MAX  = 10000;  // cycles with no transaction at all
  localparam int DRAIN_CYC  = 16;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } cal_date_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               done;
  logic [YEAR_W-1:0]  start_year;
  logic [MONTH_W-1:0] start_month;
  logic [DAY_W-1:0]   start_day;
  logic [ADD_W-1:0]   add_days;
  logic [YEAR_W-1:0]  result_year;
  logic [MONTH_W-1:0] result_month;
  logic [DAY_W-1:0]   result_day;

  gregorian_date_add_days_unit #(
    .ADD_DAYS_BITS(ADD_W)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .start_year  (start_year),
    .start_month (start_month),
    .start_day   (start_day),
    .add_days    (add_days),
    .result_year (result_year),
    .result_month(result_month),
    .result_day  (result_day)
  );

  function automatic bit is_leap(int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic int unsigned days_of_month(int unsigned yr, int unsigned mo);
    if (mo == MONTH_FEB) begin
      return is_leap(yr) ? 29 : 28;
    end
    if (mo == 4 || mo == 6 || mo == 9 || mo == 11) begin
      return 30;
    end
    return 31;
  endfunction

  class date_scoreboard;
    cal_date_t expected_dates[$];
    int        errors;

    // walk forward month by month; year counter wraps at 14 bits
    function cal_date_t advance_date(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                                     logic [DAY_W-1:0] d, logic [ADD_W-1:0] a);
      int unsigned yr;
      int unsigned mo;
      int unsigned dy;
      int unsigned len;
      cal_date_t   res;
      yr = y;
      mo = m;
      dy = d;
      if (mo < MONTH_JAN) mo = MONTH_JAN;
      if (mo > MONTH_DEC) mo = MONTH_DEC;
      if (dy < 1) dy = 1;
      dy += a;
      len = days_of_month(yr, mo);
      while (dy > len) begin
        dy -= len;
        mo++;
        if (mo > MONTH_DEC) begin
          mo = MONTH_JAN;
          yr = (yr + 1) & YEAR_TOP;
        end
        len = days_of_month(yr, mo);
      end
      res.year  = yr[YEAR_W-1:0];
      res.month = mo[MONTH_W-1:0];
      res.day   = dy[DAY_W-1:0];
      return res;
    endfunction

    function void note_request(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                               logic [DAY_W-1:0] d, logic [ADD_W-1:0] a);
      expected_dates.push_back(advance_date(y, m, d, a));
    endfunction

    function void check_result(cal_date_t got);
      cal_date_t exp_date;
      if (expected_dates.size() == 0) begin
        $error("unexpected result %0d-%0d-%0d", got.year, got.month, got.day);
        errors++;
        return;
      end
      exp_date = expected_dates.pop_front();
      if (got.year !== exp_date.year) begin
        $error("result_year: expected %0d, got %0d", exp_date.year, got.year);
        errors++;
      end
      if (got.month !== exp_date.month) begin
        $error("result_month: expected %0d, got %0d", exp_date.month, got.month);
        errors++;
      end
      if (got.day !== exp_date.day) begin
        $error("result_day: expected %0d, got %0d", exp_date.day, got.day);
        errors++;
      end
    endfunction
  endclass

  date_scoreboard date_sb;
  int             quiet_cycles;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // result monitor: done is a one-cycle strobe, values sampled pre-edge
  always @(posedge clk) begin
    if (!rst && done) begin
      date_sb.check_result('{result_year, result_month, result_day});
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
        $display("tb_gregorian_date_add_days_unit: FAIL");
        $finish;
      end
    end
  end

  // hold start high until the unit takes the transaction
  task automatic send_date(int unsigned y, int unsigned m, int unsigned d, int unsigned a);
    @(negedge clk);
    start       = 1'b1;
    start_year  = y[YEAR_W-1:0];
    start_month = m[MONTH_W-1:0];
    start_day   = d[DAY_W-1:0];
    add_days    = a[ADD_W-1:0];
    do @(posedge clk); while (busy);
    date_sb.note_request(start_year, start_month, start_day, add_days);
  endtask

  task automatic pause_start(int unsigned cycles);
    @(negedge clk);
    start = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    start = 1'b0;
    while (date_sb.expected_dates.size() != 0) @(negedge clk);
  endtask

  task automatic send_random_date();
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned a;
    int unsigned pick;
    y = ($urandom_range(99) < 80) ? $urandom_range(9999) : $urandom_range(YEAR_TOP);
    if ($urandom_range(99) < 85) begin
      m = $urandom_range(MONTH_DEC, MONTH_JAN);
      d = $urandom_range(days_of_month(y, m), 1);
    end else begin
      // out-of-range month or day, any year
      y = $urandom_range(YEAR_TOP);
      m = $urandom_range(15);
      d = $urandom_range(31);
    end
    pick = $urandom_range(99);
    if (pick < 65)      a = $urandom_range(400);
    else if (pick < 80) a = $urandom_range(4000);
    else if (pick < 95) a = $urandom_range(16'hFFFF);
    else                a = ($urandom_range(1) != 0) ? 16'hFFFF : 0;
    send_date(y, m, d, a);
  endtask

  task automatic random_phase(int unsigned count, int unsigned idle_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < idle_pct) begin
        pause_start($urandom_range(8, 1));
      end
      send_random_date();
      if (i == count / 2 && idle_pct != 0) begin
        wait_all_results();
      end
    end
  endtask

  initial begin
    date_sb      = new();
    rst          = 1'b1;
    start        = 1'b0;
    start_year   = '0;
    start_month  = '0;
    start_day    = '0;
    add_days     = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // leap rules and month/year rollover
    send_date(2024, 2, 28, 1);
    send_date(2023, 2, 28, 1);
    send_date(1900, 2, 28, 1);
    send_date(2000, 2, 28, 1);
    send_date(2100, 2, 28, 1);
    send_date(1600, 2, 29, 0);
    send_date(1999, 12, 31, 1);
    send_date(0, 1, 1, 0);
    send_date(0, 2, 28, 1);
    // extremes of the count and of the year
    send_date(9999, 12, 31, 16'hFFFF);
    send_date(2000, 1, 1, 16'hFFFF);
    send_date(1970, 1, 1, 16'h8000);
    send_date(YEAR_TOP, 12, 31, 1);
    send_date(YEAR_TOP, 1, 1, 16'hFFFF);
    send_date(16000, 6, 15, 16'hFFFF);
    // month zero, month above December, day zero
    send_date(2021, 0, 15, 20);
    send_date(2021, 13, 5, 40);
    send_date(2021, 15, 31, 1);
    send_date(2021, 6, 0, 0);
    send_date(2021, 3, 0, 31);
    // day beyond the end of its month
    send_date(2021, 2, 31, 0);
    send_date(2020, 4, 31, 0);
    send_date(2019, 2, 30, 365);
    send_date(5000, 12, 31, 0);

    wait_all_results();

    random_phase(84, 35);
    random_phase(84, 46);
    random_phase(84, 0);

    wait_all_results();
    repeat (DRAIN_CYC) @(posedge clk);

    if (date_sb.errors == 0 && date_sb.expected_dates.size() == 0) begin
      $display("tb_gregorian_date_add_days_unit: PASS");
    end else begin
      $display("tb_gregorian_date_add_days_unit: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/gdad_pkg.sv
hw/rtl/gdad_ctrl.sv
hw/rtl/gdad_dp.sv
hw/rtl/gregorian_date_add_days_unit.sv
tb/sv/tb_gregorian_date_add_days_unit.sv
